[src/hpq_pkg.sv]
// Shared types and constants for the binary max-heap priority queue.
`timescale 1ns / 1ps
`default_nettype none

package hpq_pkg;

  localparam int unsigned DEFAULT_DEPTH    = 64;
  localparam int unsigned DEFAULT_KEY_BITS = 16;
  localparam int unsigned DEFAULT_TAG_BITS = 16;

  // Fixed widths of the external fields
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned CAP_W    = 7;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } hpq_command_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } hpq_status_e;

  // Controller to datapath strobes
  typedef struct packed {
    logic accept;
    logic ins_place;
    logic ins_rd;
    logic ins_cmp;
    logic rd_root;
    logic rd_last;
    logic sd_load;
    logic sd_rd_l;
    logic sd_rd_r;
    logic sd_cmp;
    logic finish;
  } hpq_cmd_t;

  // Datapath to controller flags
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_zero;
    logic key_gt;
    logic last_one;
    logic sd_stop;
    logic out_free;
  } hpq_stat_t;

endpackage

`default_nettype wire

[src/hpq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[src/hpq_datapath.sv]
// Heap datapath: storage, index and count registers, compares, result register.
`timescale 1ns / 1ps
`default_nettype none

module hpq_datapath
  import hpq_pkg::*;
#(
  parameter int unsigned DEPTH    = DEFAULT_DEPTH,
  parameter int unsigned KEY_BITS = DEFAULT_KEY_BITS,
  parameter int unsigned TAG_BITS = DEFAULT_TAG_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire hpq_cmd_t            cmd_i,
  output hpq_stat_t                stat_o,
  input  wire logic                command_i,
  input  wire logic [FIELD_W-1:0]  key_i,
  input  wire logic [FIELD_W-1:0]  tag_i,
  input  wire logic                cfg_valid_i,
  input  wire logic [CAP_W-1:0]    cfg_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [STATUS_W-1:0] status_o,
  output logic      [FIELD_W-1:0]  out_key_o,
  output logic      [FIELD_W-1:0]  out_tag_o,
  output logic      [CAP_W-1:0]    entry_total_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned IW   = AW + 2;
  localparam int unsigned DW   = KEY_BITS + TAG_BITS;
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [CAP_W-1:0]    cap_q;
  logic [KEY_BITS-1:0] new_key_q;
  logic [TAG_BITS-1:0] new_tag_q;
  logic [DW-1:0]       hole_q;
  logic [DW-1:0]       child_q;
  logic [STATUS_W-1:0] stat_code_q;
  logic [KEY_BITS-1:0] res_key_q;
  logic [TAG_BITS-1:0] res_tag_q;
  logic                out_valid_q;

  logic [STATUS_W-1:0] status_q;
  logic [FIELD_W-1:0]  out_key_q;
  logic [FIELD_W-1:0]  out_tag_q;
  logic [CAP_W-1:0]    entry_total_q;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [DW-1:0]       wdata;
  logic [AW-1:0]       raddr;
  logic [DW-1:0]       rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [KEY_BITS-1:0] hole_key;
  logic [KEY_BITS-1:0] left_key;
  logic [KEY_BITS-1:0] best_key;

  logic [AW-1:0] idx_m1;
  logic [AW-1:0] parent;
  logic [CW-1:0] cnt_dec;
  logic [IW-1:0] lc;
  logic [IW-1:0] rc;
  logic [IW-1:0] count_ext;
  logic          lc_ok, rc_ok, gt_l, gt_r;
  logic          full, empty;

  hpq_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_key   = rdata[DW-1:TAG_BITS];
  assign hole_key = hole_q[DW-1:TAG_BITS];
  assign left_key = child_q[DW-1:TAG_BITS];

  assign idx_m1    = idx_q - 1'b1;
  assign parent    = idx_m1 >> 1;
  assign cnt_dec   = count_q - 1'b1;
  assign lc        = IW'({idx_q, 1'b1});
  assign rc        = lc + 1'b1;
  assign count_ext = IW'(count_q);

  // Sift-down choice: left child first, right only if strictly above the best so far
  assign lc_ok    = lc < count_ext;
  assign rc_ok    = rc < count_ext;
  assign gt_l     = lc_ok && (left_key > hole_key);
  assign best_key = gt_l ? left_key : hole_key;
  assign gt_r     = rc_ok && (rd_key > best_key);

  assign full  = (CMPW'(count_q) >= CMPW'(cap_q)) || (CMPW'(count_q) >= CMPW'(DEPTH));
  assign empty = (count_q == '0);

  assign stat_o.full     = full;
  assign stat_o.empty    = empty;
  assign stat_o.idx_zero = (idx_q == '0);
  assign stat_o.key_gt   = new_key_q > rd_key;
  assign stat_o.last_one = (count_q == CW'(1));
  assign stat_o.sd_stop  = !gt_l && !gt_r;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = {new_key_q, new_tag_q};
    raddr = idx_q;
    if (cmd_i.ins_place) begin
      we = 1'b1;
    end
    if (cmd_i.ins_rd) begin
      raddr = parent;
    end
    if (cmd_i.ins_cmp) begin
      we = 1'b1;
      if (new_key_q > rd_key) begin
        wdata = rdata;
      end
    end
    if (cmd_i.rd_root) begin
      raddr = '0;
    end
    if (cmd_i.rd_last) begin
      raddr = cnt_dec[AW-1:0];
    end
    if (cmd_i.sd_rd_l) begin
      raddr = lc[AW-1:0];
    end
    if (cmd_i.sd_rd_r) begin
      raddr = rc[AW-1:0];
    end
    if (cmd_i.sd_cmp) begin
      we = 1'b1;
      if (gt_r) begin
        wdata = rdata;
      end else if (gt_l) begin
        wdata = child_q;
      end else begin
        wdata = hole_q;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.accept && command_i == CMD_INSERT && !full) begin
      count_d = count_q + 1'b1;
      idx_d   = count_q[AW-1:0];
    end
    if (cmd_i.ins_cmp && (new_key_q > rd_key)) begin
      idx_d = parent;
    end
    if (cmd_i.rd_last) begin
      count_d = cnt_dec;
      idx_d   = '0;
    end
    if (cmd_i.sd_cmp) begin
      if (gt_r) begin
        idx_d = rc[AW-1:0];
      end else if (gt_l) begin
        idx_d = lc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      new_key_q <= KEY_BITS'(key_i);
      new_tag_q <= TAG_BITS'(tag_i);
      res_key_q <= '0;
      res_tag_q <= '0;
      if (command_i == CMD_INSERT) begin
        stat_code_q <= full ? STATUS_FULL : STATUS_DONE;
      end else begin
        stat_code_q <= empty ? STATUS_EMPTY : STATUS_DONE;
      end
    end
    if (cmd_i.rd_last) begin
      res_key_q <= rd_key;
      res_tag_q <= rdata[TAG_BITS-1:0];
    end
    if (cmd_i.sd_load) begin
      hole_q <= rdata;
    end
    if (cmd_i.sd_rd_r) begin
      child_q <= rdata;
    end
    if (cmd_i.finish) begin
      status_q      <= stat_code_q;
      out_key_q     <= FIELD_W'(res_key_q);
      out_tag_q     <= FIELD_W'(res_tag_q);
      entry_total_q <= CAP_W'(count_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_key_o     = out_key_q;
  assign out_tag_o     = out_tag_q;
  assign entry_total_o = entry_total_q;

endmodule

`default_nettype wire

[src/hpq_controller.sv]
// Heap controller: sequences insert sift-up and remove sift-down steps.
`timescale 1ns / 1ps
`default_nettype none

module hpq_controller
  import hpq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire logic      command_i,
  input  wire hpq_stat_t stat_i,
  output hpq_cmd_t       cmd_o
);

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_INS_RD   = 11'b000_0000_0010,
    ST_INS_CMP  = 11'b000_0000_0100,
    ST_REM_ROOT = 11'b000_0000_1000,
    ST_REM_LAST = 11'b000_0001_0000,
    ST_SD_LOAD  = 11'b000_0010_0000,
    ST_SD_RD_L  = 11'b000_0100_0000,
    ST_SD_RD_R  = 11'b000_1000_0000,
    ST_SD_CMP   = 11'b001_0000_0000,
    ST_FINISH   = 11'b010_0000_0000,
    ST_SPARE    = 11'b100_0000_0000
  } hpq_state_e;

  hpq_state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (command_i == CMD_INSERT) begin
            state_d = stat_i.full ? ST_FINISH : ST_INS_RD;
          end else begin
            state_d = stat_i.empty ? ST_FINISH : ST_REM_ROOT;
          end
        end
      end
      ST_INS_RD: begin
        if (stat_i.idx_zero) begin
          cmd_o.ins_place = 1'b1;
          state_d         = ST_FINISH;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        // Move the parent down, or drop the new pair into the hole
        cmd_o.ins_cmp = 1'b1;
        state_d       = stat_i.key_gt ? ST_INS_RD : ST_FINISH;
      end
      ST_REM_ROOT: begin
        cmd_o.rd_root = 1'b1;
        state_d       = ST_REM_LAST;
      end
      ST_REM_LAST: begin
        cmd_o.rd_last = 1'b1;
        state_d       = stat_i.last_one ? ST_FINISH : ST_SD_LOAD;
      end
      ST_SD_LOAD: begin
        cmd_o.sd_load = 1'b1;
        state_d       = ST_SD_RD_L;
      end
      ST_SD_RD_L: begin
        cmd_o.sd_rd_l = 1'b1;
        state_d       = ST_SD_RD_R;
      end
      ST_SD_RD_R: begin
        cmd_o.sd_rd_r = 1'b1;
        state_d       = ST_SD_CMP;
      end
      ST_SD_CMP: begin
        cmd_o.sd_cmp = 1'b1;
        state_d      = stat_i.sd_stop ? ST_FINISH : ST_SD_RD_L;
      end
      ST_FINISH: begin
        // Hold until the output register is free
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[src/binary_max_heap_priority_queue.sv]
// Top level of the binary max-heap priority queue of key and tag pairs.
// Usage:
//   Input channel (in_valid_i / in_stall_o): command_i 0 inserts {key_i, tag_i},
//   1 removes the pair with the largest key. A transaction completes when valid
//   is high and stall is low; the block stalls while one item is in progress.
//   Output channel (out_valid_o / out_stall_i): one result per item carrying
//   status_o, the removed pair and entry_total_o. The result sits in an output
//   register, so the next item is taken while a result still waits.
//   Configuration (cfg_valid_i / cfg_ready_o): writes capacity_limit; always
//   ready, write only while the block is idle.
// Each item is sequenced through the single registered read port of the heap RAM.
// A refused item goes straight to loading its result. An insert climbs one
//   level per parent read and compare, stopping at the root or at a parent that
//   is not smaller. A remove reads the root and then the last entry, finishes at
//   once when that empties the heap, else loads the last entry as the hole and
//   sinks it one level per left read, right read and compare. The next item is
//   taken in the cycle after the result is loaded.
// Reset clears the entry count, sets capacity_limit to 64 and drops any pending
// result; heap storage is not cleared. A stalled receiver holds the result and
// stops the block from finishing the following item.
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_priority_queue
  import hpq_pkg::*;
#(
  parameter int unsigned DEPTH    = DEFAULT_DEPTH,
  parameter int unsigned KEY_BITS = DEFAULT_KEY_BITS,
  parameter int unsigned TAG_BITS = DEFAULT_TAG_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                command_i,
  input  wire logic [FIELD_W-1:0]  key_i,
  input  wire logic [FIELD_W-1:0]  tag_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [STATUS_W-1:0] status_o,
  output logic      [FIELD_W-1:0]  out_key_o,
  output logic      [FIELD_W-1:0]  out_tag_o,
  output logic      [CAP_W-1:0]    entry_total_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CAP_W-1:0]    cfg_data_i
);

  hpq_cmd_t  cmd;
  hpq_stat_t stat;

  assign cfg_ready_o = 1'b1;

  hpq_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hpq_datapath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .command_i     (command_i),
    .key_i         (key_i),
    .tag_i         (tag_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_key_o     (out_key_o),
    .out_tag_o     (out_tag_o),
    .entry_total_o (entry_total_o)
  );

endmodule

`default_nettype wire

[dv/binary_max_heap_priority_queue_tb.sv]
// Self-checking testbench for the binary max-heap priority queue: directed table, then random.
`timescale 1ns / 1ps

module binary_max_heap_priority_queue_tb;
  import hpq_pkg::*;

  localparam int unsigned HEAP_SLOTS = DEFAULT_DEPTH;

  typedef struct packed {
    hpq_status_e        status;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] tag;
    logic [CAP_W-1:0]   total;
  } heap_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CAP
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CAP_W-1:0]   cap;
    hpq_command_e       cmd;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] tag;
    logic               typed;
    heap_result_t       want;
  } stim_row_t;

  localparam heap_result_t NO_TYPED = '{STATUS_DONE, 16'h0000, 16'h0000, 7'd0};

  // Directed rows; typed expectations only where the answer is plain
  localparam int unsigned N_ROWS = 30;
  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{ROW_ITEM, 7'd0, CMD_REMOVE, 16'h0000, 16'h0000, 1'b1,
      '{STATUS_EMPTY, 16'h0000, 16'h0000, 7'd0}},
    '{ROW_ITEM, 7'd0, CMD_INSERT, 16'h0000, 16'h0000, 1'b1,
      '{STATUS_DONE, 16'h0000, 16'h0000, 7'd1}},
    '{ROW_ITEM, 7'd0, CMD_INSERT, 16'hFFFF, 16'hFFFF, 1'b1,
      '{STATUS_DONE, 16'h0000, 16'h0000, 7'd2}},
    '{ROW_ITEM, 7'd0, CMD_INSERT, 16'h8000, 16'h1234, 1'b0, NO_TYPED},
    '{ROW_ITEM, 7'd0, CMD_INSERT, 16'h8000, 16'h5678, 1'b0, NO_TYPED},
    '{ROW_ITEM, 7'd0, CMD_INSERT, 16'h8000, 16'hAAAA, 1'b0, NO_TYPED},
    '{ROW_ITEM, 7'd0, CMD_REMOVE, 16'h0000, 16'h0000, 1'b1,
      '{STATUS_DONE, 16'hFFFF, 16'hFFFF, 7'd4}},
    '{ROW_ITEM, 7'd0, CMD_REMOVE, 16'hFFFF, 16'hFFFF, 1'b0, NO_TYPED},
    '{ROW_ITEM, 7'd0, CMD_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_TYPED},
    '{ROW_ITEM, 7'd0, CMD_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_TYPED},
    '{ROW_ITEM, 7'd0, CMD_REMOVE, 16'h0000, 16'h0000, 1'b1,
      '{STATUS_DONE, 16'h0000, 16'h0000, 7'd0}},
    '{ROW_ITEM, 7'd0, CMD_REMOVE, 16'h0000, 16'h0000, 1'b1,
      '{STATUS_EMPTY, 16'h0000, 16'h0000, 7'd0}},
    '{ROW_CAP, 7'd1, CMD_INSERT, 16'h0000, 16'h0000, 1'b0, NO_TYPED},
    '{ROW_ITEM, 7'd0, CMD_INSERT, 16'h5555, 16'hAAAA, 1'b1,
      '{STATUS_DONE, 16'h0000, 16'h0000, 7'd1}},
    '{ROW_ITEM, 7'd0, CMD_INSERT, 16'hAAAA, 16'h5555, 1'b1,
      '{STATUS_FULL, 16'h0000, 16'h0000, 7'd1}},
    '{ROW_CAP, 7'd0, CMD_INSERT, 16'h0000, 16'h0000, 1'b0, NO_TYPED},
    '{ROW_ITEM, 7'd0, CMD_INSERT, 16'h0001, 16'h0001, 1'b1,
      '{STATUS_FULL, 16'h0000, 16'h0000, 7'd1}},
    '{ROW_ITEM, 7'd0, CMD_REMOVE, 16'h0000, 16'h0000, 1'b1,
      '{STATUS_DONE, 16'h5555, 16'hAAAA, 7'd0}},
    '{ROW_ITEM, 7'd0, CMD_INSERT, 16'h0000, 16'h0000, 1'b1,
      '{STATUS_FULL, 16'h0000, 16'h0000, 7'd0}},
    '{ROW_CAP, 7'd127, CMD_INSERT, 16'h0000, 16'h0000, 1'b0, NO_TYPED},
    '{ROW_ITEM, 7'd0, CMD_INSERT, 16'h1234, 16'h0001, 1'b0, NO_TYPED},
    '{ROW_ITEM, 7'd0, CMD_INSERT, 16'h4321, 16'h0002, 1'b0, NO_TYPED},
    '{ROW_ITEM, 7'd0, CMD_INSERT, 16'h7FFF, 16'h0003, 1'b0, NO_TYPED},
    '{ROW_CAP, 7'd2, CMD_INSERT, 16'h0000, 16'h0000, 1'b0, NO_TYPED},
    '{ROW_ITEM, 7'd0, CMD_INSERT, 16'hFFFF, 16'h0004, 1'b1,
      '{STATUS_FULL, 16'h0000, 16'h0000, 7'd3}},
    '{ROW_ITEM, 7'd0, CMD_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_TYPED},
    '{ROW_ITEM, 7'd0, CMD_INSERT, 16'h0000, 16'h0000, 1'b1,
      '{STATUS_FULL, 16'h0000, 16'h0000, 7'd2}},
    '{ROW_ITEM, 7'd0, CMD_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_TYPED},
    '{ROW_ITEM, 7'd0, CMD_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_TYPED},
    '{ROW_CAP, 7'd64, CMD_INSERT, 16'h0000, 16'h0000, 1'b0, NO_TYPED}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  hpq_command_e       command_i = CMD_INSERT;
  logic [FIELD_W-1:0] key_i = '0;
  logic [FIELD_W-1:0] tag_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [FIELD_W-1:0] out_key_o;
  logic [FIELD_W-1:0] out_tag_o;
  logic [CAP_W-1:0]   entry_total_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CAP_W-1:0]   cfg_data_i = '0;

  // Predictor state
  logic [FIELD_W-1:0] heap_keys [HEAP_SLOTS];
  logic [FIELD_W-1:0] heap_tags [HEAP_SLOTS];
  int unsigned        heap_count;
  int unsigned        capacity;

  heap_result_t       pending_results [$];
  heap_result_t       oldest;
  int unsigned        error_count;
  bit                 steady;

  binary_max_heap_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .key_i         (key_i),
    .tag_i         (tag_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_key_o     (out_key_o),
    .out_tag_o     (out_tag_o),
    .entry_total_o (entry_total_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("binary_max_heap_priority_queue_tb: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                 input logic [FIELD_W-1:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  function automatic int unsigned usable_capacity();
    return (capacity > HEAP_SLOTS) ? HEAP_SLOTS : capacity;
  endfunction

  // Apply one command to the predictor and return the result it should give
  function automatic heap_result_t heap_apply(input hpq_command_e cmd,
                                              input logic [FIELD_W-1:0] key,
                                              input logic [FIELD_W-1:0] tag);
    heap_result_t       res;
    int unsigned        at;
    int unsigned        up;
    int unsigned        best;
    int unsigned        lc;
    int unsigned        rc;
    logic [FIELD_W-1:0] swap_key;
    logic [FIELD_W-1:0] swap_tag;
    bit                 settled;
    res = NO_TYPED;
    if (cmd == CMD_INSERT) begin
      if (heap_count >= usable_capacity()) begin
        res.status = STATUS_FULL;
      end else begin
        at = heap_count;
        heap_count++;
        // climb while strictly greater than the parent
        while (at > 0 && key > heap_keys[(at - 1) / 2]) begin
          up = (at - 1) / 2;
          heap_keys[at] = heap_keys[up];
          heap_tags[at] = heap_tags[up];
          at = up;
        end
        heap_keys[at] = key;
        heap_tags[at] = tag;
      end
    end else if (heap_count == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.key = heap_keys[0];
      res.tag = heap_tags[0];
      heap_count--;
      heap_keys[0] = heap_keys[heap_count];
      heap_tags[0] = heap_tags[heap_count];
      at = 0;
      settled = 1'b0;
      // sink; left child wins a tie, swap only on a strictly greater key
      while (!settled) begin
        best = at;
        lc = 2 * at + 1;
        rc = 2 * at + 2;
        if (lc < heap_count && heap_keys[lc] > heap_keys[best]) best = lc;
        if (rc < heap_count && heap_keys[rc] > heap_keys[best]) best = rc;
        if (best == at) begin
          settled = 1'b1;
        end else begin
          swap_key = heap_keys[at];
          swap_tag = heap_tags[at];
          heap_keys[at] = heap_keys[best];
          heap_tags[at] = heap_tags[best];
          heap_keys[best] = swap_key;
          heap_tags[best] = swap_tag;
          at = best;
        end
      end
    end
    res.total = heap_count[CAP_W-1:0];
    return res;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the transaction
  task automatic send_item(input hpq_command_e cmd, input logic [FIELD_W-1:0] key,
                           input logic [FIELD_W-1:0] tag, input logic typed,
                           input heap_result_t typed_res);
    heap_result_t predicted;
    while (!steady && $urandom_range(0, 99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    key_i      <= key;
    tag_i      <= tag;
    do @(posedge clk_i); while (in_stall_o);
    predicted = heap_apply(cmd, key, tag);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic wait_idle(input int unsigned tail);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    capacity = value;
  endtask

  function automatic logic [FIELD_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0:       return FIELD_W'($urandom_range(0, 7));
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return FIELD_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Mostly fill-then-drain runs with random content, the rest mixed commands
  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned i;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(1, usable_capacity() + 2);
        if (len > n_items - sent) len = n_items - sent;
        for (i = 0; i < len; i++)
          send_item(CMD_INSERT, pick_key(), FIELD_W'($urandom_range(0, 16'hFFFF)),
                    1'b0, NO_TYPED);
        sent += len;
        len = $urandom_range(1, heap_count + 2);
        if (len > n_items - sent) len = n_items - sent;
        for (i = 0; i < len; i++)
          send_item(CMD_REMOVE, FIELD_W'($urandom_range(0, 16'hFFFF)),
                    FIELD_W'($urandom_range(0, 16'hFFFF)), 1'b0, NO_TYPED);
        sent += len;
      end else begin
        len = $urandom_range(1, 8);
        if (len > n_items - sent) len = n_items - sent;
        for (i = 0; i < len; i++)
          send_item(hpq_command_e'($urandom_range(0, 1)), pick_key(),
                    FIELD_W'($urandom_range(0, 16'hFFFF)), 1'b0, NO_TYPED);
        sent += len;
      end
    end
  endtask

  // Receiver: stall at random, check each transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, key", out_key_o, 16'h0000);
      end else begin
        oldest = pending_results.pop_front();
        if (status_o !== oldest.status)
          report_mismatch("status", FIELD_W'(status_o), FIELD_W'(oldest.status));
        if (out_key_o !== oldest.key)
          report_mismatch("out_key", out_key_o, oldest.key);
        if (out_tag_o !== oldest.tag)
          report_mismatch("out_tag", out_tag_o, oldest.tag);
        if (entry_total_o !== oldest.total)
          report_mismatch("entry_total", FIELD_W'(entry_total_o), FIELD_W'(oldest.total));
      end
    end
    out_stall_i <= !steady && ($urandom_range(0, 99) < 26);
  end

  initial begin
    int unsigned row;
    int unsigned ph;
    int unsigned phase_caps [8] = '{64, 1, 127, 5, 0, 33, 64, 2};
    error_count = 0;
    steady      = 1'b0;
    heap_count  = 0;
    capacity    = CAP_RESET;
    phase_caps[5] = $urandom_range(2, 63);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle(4);

    for (row = 0; row < N_ROWS; row++) begin
      if (DIRECTED_ROWS[row].kind == ROW_CAP) begin
        wait_idle(4);
        write_capacity(DIRECTED_ROWS[row].cap);
      end else begin
        send_item(DIRECTED_ROWS[row].cmd, DIRECTED_ROWS[row].key, DIRECTED_ROWS[row].tag,
                  DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].want);
      end
    end

    for (ph = 0; ph < 8; ph++) begin
      wait_idle(4);
      write_capacity(CAP_W'(phase_caps[ph]));
      // one phase runs with neither side idling
      steady = (ph == 6);
      run_random((phase_caps[ph] == 0) ? 20 : 180);
    end
    steady = 1'b0;

    wait_idle(40);
    if (pending_results.size() != 0)
      report_mismatch("results left over", FIELD_W'(pending_results.size()), 16'h0000);
    if (error_count == 0) begin
      $display("binary_max_heap_priority_queue_tb: done, clean");
    end else begin
      $display("binary_max_heap_priority_queue_tb: done, errors");
    end
    $finish;
  end

endmodule
